// ===== rtl/bsrs_pkg.sv =====
// Shared types and constants for the bus slot reservation scheduler.
package bsrs_pkg;

  localparam int unsigned SLOTS      = 8;
  localparam int unsigned SLOT_IDX_W = $clog2(SLOTS);
  localparam int unsigned TIME_W     = 32;

  typedef logic [TIME_W-1:0] time_t;

  typedef struct packed {
    time_t req_time;
    time_t duration;
  } req_t;

  typedef struct packed {
    logic  status;
    time_t scheduled_start;
    time_t wait_time;
    time_t time_added;
  } rsp_t;

  // One reserved interval [beg_time, end_time).
  typedef struct packed {
    logic  valid;
    time_t beg_time;
    time_t end_time;
  } entry_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_EXPIRE,
    OP_COMPACT,
    OP_ROTATE,
    OP_INSERT,
    OP_CLEAR
  } cell_op_e;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    cell_op_e op;
    time_t    req_time;
    entry_t   new_entry;
  } cell_ctrl_t;

endpackage

// ===== rtl/bsrs_if.sv =====
// Valid/ready request and response channels.
interface bsrs_req_if;
  import bsrs_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bsrs_rsp_if;
  import bsrs_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/bsrs_cell.sv =====
// One table cell: holds a reservation and trades it with its neighbors.
module bsrs_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bsrs_pkg::cell_ctrl_t ctrl_i,
  input  bsrs_pkg::entry_t    left_i,
  input  logic                left_gt_i,
  input  bsrs_pkg::entry_t    right_i,
  input  logic                hole_i,
  output bsrs_pkg::entry_t    entry_o,
  output logic                gt_o,
  output logic                hole_o
);
  import bsrs_pkg::*;

  logic   valid_q, valid_d;
  time_t  beg_q, beg_d;
  time_t  end_q, end_d;
  entry_t cur, nxt;

  assign cur = '{valid: valid_q, beg_time: beg_q, end_time: end_q};
  assign entry_o = cur;
  assign hole_o = hole_i | ~valid_q;

  // Ordered by begin, then end.
  assign gt_o = valid_q && ((beg_q > ctrl_i.new_entry.beg_time) ||
                ((beg_q == ctrl_i.new_entry.beg_time) &&
                 (end_q > ctrl_i.new_entry.end_time)));

  always_comb begin
    nxt = cur;
    unique case (ctrl_i.op)
      OP_EXPIRE: begin
        if (valid_q && (end_q <= ctrl_i.req_time)) nxt.valid = 1'b0;
      end
      OP_COMPACT: begin
        if (hole_i || !valid_q) nxt = right_i;
      end
      OP_ROTATE: nxt = right_i;
      OP_INSERT: begin
        // only the first later-or-empty cell takes the new entry
        if (left_gt_i) begin
          nxt = left_i;
        end else if ((gt_o || !valid_q) && !hole_i) begin
          nxt = ctrl_i.new_entry;
        end
      end
      OP_CLEAR: nxt.valid = 1'b0;
      default: nxt = cur;
    endcase
  end

  assign valid_d = nxt.valid;
  assign beg_d   = nxt.beg_time;
  assign end_d   = nxt.end_time;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    beg_q <= beg_d;
    end_q <= end_d;
  end

endmodule

// ===== rtl/bus_slot_reservation_scheduler_top.sv =====
// Top level of the bus slot reservation scheduler.
//
// Keeps up to SLOTS reserved bus intervals in a row of cells sorted by begin
// time (ties by end). Each request {req_time, duration} runs a sequence: an
// expire step frees intervals that end at or before req_time, compaction
// squeezes out freed cells (one hole per cycle), the row is rotated once
// past cell 0 to run the first-fit scan on each adjacent pair, and an insert
// step puts the new interval at its sorted place. The result then goes to
// the output register; a new request is accepted only in idle, once the
// previous one has reached the output register. A table still full after
// expiry is cleared at once and the request is rejected with full_penalty.
// The output register lets a new request be taken while the previous response
// waits. Interval ends saturate at the top of the 32-bit time range. The user
// must write full_penalty via cfg_we_i/cfg_wdata_i only while the block is
// idle; the block itself does not enforce this.
module bus_slot_reservation_scheduler_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  bsrs_pkg::time_t  cfg_wdata_i,
  bsrs_req_if.sink         req,
  bsrs_rsp_if.source       rsp
);
  import bsrs_pkg::*;

  localparam logic [SLOT_IDX_W-1:0] IDX_LAST = SLOT_IDX_W'(SLOTS - 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_EXPIRE  = 6'b000010,
    S_COMPACT = 6'b000100,
    S_SCAN    = 6'b001000,
    S_INSERT  = 6'b010000,
    S_DONE    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [SLOT_IDX_W-1:0] k_q, k_d;
  time_t start_q, start_d, dur_q, dur_d;
  time_t pen_q, pen_d;
  logic found_q, found_d;
  time_t sched_q, sched_d, last_q, last_d;
  rsp_t res_q, res_d;
  logic rsp_valid_q, rsp_valid_d;
  rsp_t rsp_q, rsp_d;

  cell_ctrl_t ctrl;
  entry_t e [SLOTS];
  logic gt [SLOTS];
  logic hole [SLOTS+1];
  logic all_valid;

  // Row of cells
  assign hole[0] = 1'b0;
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    entry_t left_e, right_e;
    logic left_gt;
    if (i == 0) begin : g_first
      assign left_e  = '0;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left_e  = e[i-1];
      assign left_gt = gt[i-1];
    end
    if (i == SLOTS - 1) begin : g_last
      // wrap for rotation, feed an empty cell while compacting
      assign right_e = (ctrl.op == OP_ROTATE) ? e[0] : '0;
    end else begin : g_inner
      assign right_e = e[i+1];
    end
    bsrs_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .left_i    (left_e),
      .left_gt_i (left_gt),
      .right_i   (right_e),
      .hole_i    (hole[i]),
      .entry_o   (e[i]),
      .gt_o      (gt[i]),
      .hole_o    (hole[i+1])
    );
  end

  always_comb begin
    all_valid = 1'b1;
    for (int i = 0; i < SLOTS; i++) all_valid &= e[i].valid;
  end

  // Scan terms: cell 0 holds the k-th entry in order, cell 1 the next.
  logic pair_ok, b0_fit, last_here;
  logic [TIME_W:0] end_sum;
  time_t final_sched;

  assign pair_ok = e[0].valid && e[1].valid && (k_q != IDX_LAST);
  assign b0_fit = (e[0].beg_time > start_q) && ((e[0].beg_time - start_q) >= dur_q);
  assign last_here = e[0].valid && !pair_ok;
  assign final_sched = found_q ? sched_q : last_q;
  assign end_sum = {1'b0, final_sched} + {1'b0, dur_q};

  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid = rsp_valid_q;
  assign rsp.payload = rsp_q;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    start_d     = start_q;
    dur_d       = dur_q;
    pen_d       = cfg_we_i ? cfg_wdata_i : pen_q;
    found_d     = found_q;
    sched_d     = sched_q;
    last_d      = last_q;
    res_d       = res_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    ctrl.op     = OP_HOLD;
    ctrl.req_time = start_q;
    ctrl.new_entry = '{valid: 1'b1, beg_time: final_sched,
                       end_time: end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0]};

    if (rsp_valid_q && rsp.ready) rsp_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          start_d = req.payload.req_time;
          dur_d   = req.payload.duration;
          state_d = S_EXPIRE;
        end
      end
      S_EXPIRE: begin
        ctrl.op = OP_EXPIRE;
        k_d     = '0;
        found_d = 1'b0;
        state_d = S_COMPACT;
      end
      S_COMPACT: begin
        if ((k_q == '0) && all_valid) begin
          // still full: drop every reservation and reject
          ctrl.op = OP_CLEAR;
          res_d   = '{status: 1'b1, scheduled_start: start_q,
                      wait_time: '0, time_added: pen_q};
          state_d = S_DONE;
        end else begin
          ctrl.op = OP_COMPACT;
          if (k_q == IDX_LAST) begin
            k_d     = '0;
            state_d = S_SCAN;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      S_SCAN: begin
        ctrl.op = OP_ROTATE;
        if (!found_q) begin
          priority if ((k_q == '0) && !e[0].valid) begin
            found_d = 1'b1;
            sched_d = start_q;
          end else if ((k_q == '0) && b0_fit) begin
            found_d = 1'b1;
            sched_d = start_q;
          end else if (pair_ok && (e[0].end_time >= start_q) &&
                       (e[1].beg_time >= e[0].end_time) &&
                       ((e[1].beg_time - e[0].end_time) >= dur_q)) begin
            found_d = 1'b1;
            sched_d = e[0].end_time;
          end
        end
        if (last_here) last_d = e[0].end_time;
        if (k_q == IDX_LAST) begin
          state_d = S_INSERT;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_INSERT: begin
        ctrl.op = OP_INSERT;
        res_d   = '{status: 1'b0, scheduled_start: final_sched,
                    wait_time: final_sched - start_q,
                    time_added: final_sched - start_q};
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp.ready) begin
          rsp_valid_d = 1'b1;
          rsp_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      pen_q       <= '0;
      found_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      pen_q       <= pen_d;
      found_q     <= found_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    dur_q   <= dur_d;
    sched_q <= sched_d;
    last_q  <= last_d;
    res_q   <= res_d;
    rsp_q   <= rsp_d;
  end

endmodule

// ===== sim/bsrs_checker.sv =====
// Checker for the bus slot reservation scheduler: predicts each response and compares.
module bsrs_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  bsrs_pkg::time_t  cfg_wdata_i,
  input  logic             req_valid_i,
  input  logic             req_ready_i,
  input  bsrs_pkg::req_t   req_payload_i,
  input  logic             rsp_valid_i,
  input  logic             rsp_ready_i,
  input  bsrs_pkg::rsp_t   rsp_payload_i,
  output int               err_count_o,
  output int               pending_o,
  output int               rejects_o,
  output int               responses_o
);
  import bsrs_pkg::*;

  time_t  penalty_q;
  time_t  res_beg [SLOTS];
  time_t  res_end [SLOTS];
  logic   res_vld [SLOTS];
  rsp_t   expected_rsps [$];

  assign pending_o = expected_rsps.size();

  function automatic bit earlier(int a, int b);
    if (res_beg[a] != res_beg[b]) return res_beg[a] < res_beg[b];
    if (res_end[a] != res_end[b]) return res_end[a] < res_end[b];
    return a < b;
  endfunction

  // Expire, reject on a full table, else first fit, then store in the lowest free entry.
  task automatic schedule_request(input req_t r);
    int    order [SLOTS];
    int    n;
    int    m;
    bit    found;
    time_t sched;
    time_t ea;
    time_t bb;
    logic [32:0] sum;
    rsp_t  p;
    n = 0;
    found = 0;
    for (int k = 0; k < SLOTS; k++)
      if (res_vld[k] && res_end[k] <= r.req_time) res_vld[k] = 0;
    for (int k = 0; k < SLOTS; k++) if (res_vld[k]) n++;
    if (n == SLOTS) begin
      for (int k = 0; k < SLOTS; k++) res_vld[k] = 0;
      p.status = 1'b1;
      p.scheduled_start = r.req_time;
      p.wait_time = '0;
      p.time_added = penalty_q;
      expected_rsps.push_back(p);
      rejects_o++;
      return;
    end
    n = 0;
    for (int k = 0; k < SLOTS; k++) begin
      if (res_vld[k]) begin
        m = n;
        while (m > 0 && earlier(k, order[m-1])) begin
          order[m] = order[m-1];
          m--;
        end
        order[m] = k;
        n++;
      end
    end
    if (n == 0) begin
      sched = r.req_time;
    end else begin
      sched = '0;
      if (res_beg[order[0]] > r.req_time &&
          res_beg[order[0]] - r.req_time >= r.duration) begin
        sched = r.req_time;
        found = 1;
      end
      for (int k = 0; !found && k + 1 < n; k++) begin
        ea = res_end[order[k]];
        bb = res_beg[order[k+1]];
        if (ea >= r.req_time && bb >= ea && bb - ea >= r.duration) begin
          sched = ea;
          found = 1;
        end
      end
      if (!found) sched = res_end[order[n-1]];
      if (sched < r.req_time) sched = r.req_time;
    end
    for (int k = 0; k < SLOTS; k++) begin
      if (!res_vld[k]) begin
        res_vld[k] = 1;
        res_beg[k] = sched;
        sum = {1'b0, sched} + {1'b0, r.duration};
        res_end[k] = sum[32] ? '1 : sum[31:0];
        break;
      end
    end
    p.status = 1'b0;
    p.scheduled_start = sched;
    p.wait_time = sched - r.req_time;
    p.time_added = sched - r.req_time;
    expected_rsps.push_back(p);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      penalty_q = '0;
      for (int k = 0; k < SLOTS; k++) res_vld[k] = 0;
      expected_rsps.delete();
      err_count_o = 0;
      rejects_o = 0;
      responses_o = 0;
    end else begin
      if (cfg_we_i) penalty_q = cfg_wdata_i;
      if (rsp_valid_i && rsp_ready_i) begin
        responses_o++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response %p", $time, rsp_payload_i);
          err_count_o++;
        end else begin
          e = expected_rsps.pop_front();
          if (e !== rsp_payload_i) begin
            $display("%0t: response mismatch exp %p got %p", $time, e, rsp_payload_i);
            err_count_o++;
          end
        end
      end
      if (req_valid_i && req_ready_i) schedule_request(req_payload_i);
    end
  end
endmodule

// ===== sim/bus_slot_reservation_scheduler_top_tb.sv =====
// Testbench top: drives requests and penalty writes, gives the verdict.
module bus_slot_reservation_scheduler_top_tb;
  import bsrs_pkg::*;

  localparam int LATENCY   = 2 * SLOTS + 6;   // margin past the per-request sequence and output stage
  localparam int WATCHDOG  = 20000;           // cycles with no handshake at all
  localparam int N_RANDOM  = 800;

  logic  clk_i = 0;
  logic  rst_ni = 0;
  logic  cfg_we_i = 0;
  time_t cfg_wdata_i = '0;

  bsrs_req_if req ();
  bsrs_rsp_if rsp ();

  int err_count, pending, rejects, responses;
  int quiet_cycles;
  bit hold_off;       // long receiver stall requested by stimulus
  bit calm;           // no random idling on either side
  bit done;
  int accepted;
  time_t last_end;    // drives well-formed, roughly increasing request times

  bus_slot_reservation_scheduler_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req.sink),
    .rsp         (rsp.source)
  );

  bsrs_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_valid_i   (req.valid),
    .req_ready_i   (req.ready),
    .req_payload_i (req.payload),
    .rsp_valid_i   (rsp.valid),
    .rsp_ready_i   (rsp.ready),
    .rsp_payload_i (rsp.payload),
    .err_count_o   (err_count),
    .pending_o     (pending),
    .rejects_o     (rejects),
    .responses_o   (responses)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    req.valid = 0;
    req.payload = '0;
    rsp.ready = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
  end

  // Response side: random back-pressure, plus a long hold-off on request.
  initial begin
    int stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off && stall == 0) stall = 300;
      if (stall > 0) begin
        stall--;
        rsp.ready <= 1'b0;
        if (stall == 0) hold_off = 0;
      end else begin
        rsp.ready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
      end
    end
  end

  // Watchdog: nothing accepted on either channel for too long ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG) begin
        $display("watchdog expired, %0d responses outstanding", pending);
        $display("FAIL bus_slot_reservation_scheduler_top");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // Offer one request, with random idle cycles ahead of it unless calm. Valid stays up
  // after the handshake until the next request or an idle cycle replaces it.
  task automatic send_request(input time_t st, input time_t dur);
    if (!calm) begin
      while ($urandom_range(99) < 9) begin
        req.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req.valid <= 1'b1;
    req.payload <= '{req_time: st, duration: dur};
    do @(posedge clk_i); while (!req.ready);
    accepted++;
  endtask

  // Penalty write only when the block has drained.
  task automatic write_penalty(input time_t v);
    req.valid <= 1'b0;
    repeat (LATENCY) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random request: mostly a stream of times that march forward with short
  // durations so intervals overlap, fill and expire; some pure noise.
  task automatic random_request();
    time_t st;
    time_t dur;
    int sel;
    sel = $urandom_range(99);
    if (sel < 80) begin
      st = last_end + $urandom_range(40);
      dur = $urandom_range(60);
      if ($urandom_range(9) == 0) st = last_end - $urandom_range(30);
      last_end = st + $urandom_range(15);
    end else if (sel < 90) begin
      st = $urandom;
      dur = $urandom;
    end else begin
      st = 32'hFFFF_FF00 | $urandom_range(255);
      dur = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom_range(512);
    end
    send_request(st, dur);
  endtask

  initial begin
    time_t penalties [4];
    penalties = '{32'h0, 32'hFFFF_FFFF, 32'h0000_0123, 32'h8000_0001};
    quiet_cycles = 0;
    hold_off = 0;
    calm = 0;
    accepted = 0;
    last_end = 32'd1000;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed: empty table, fit before earliest, gap fill, after last,
    // saturating end, zero duration, then a full table that is rejected.
    write_penalty(32'hFFFF_FFFF);
    send_request(32'd100, 32'd10);           // empty table
    send_request(32'd50, 32'd50);            // fits exactly before earliest
    send_request(32'd50, 32'd5);             // no room before: goes after
    send_request(32'd300, 32'd20);
    send_request(32'd100, 32'd100);          // fits before earliest
    send_request(32'd0, 32'd0);              // zero duration
    send_request(32'hFFFF_FFF0, 32'hFFFF_FFFF); // end saturates
    send_request(32'd0, 32'h7FFF_FFFF);
    send_request(32'd1, 32'd1);              // first gap long enough
    send_request(32'd0, 32'd0);
    send_request(32'hFFFF_FFFF, 32'd0);      // expires everything
    for (int k = 0; k < 9; k++) send_request(32'd5, 32'hFFFF_FFFF); // fill, reject
    write_penalty(32'h0);
    send_request(32'h8000_0000, 32'h8000_0000);
    for (int k = 0; k < 9; k++) send_request(32'h8000_0000, 32'd1);

    // Random phases, each with its own penalty; one with no idling and one
    // with a long receiver hold-off while requests keep coming.
    for (int ph = 0; ph < 4; ph++) begin
      write_penalty(penalties[ph]);
      calm = (ph == 1);
      if (ph == 2) hold_off = 1;
      for (int k = 0; k < N_RANDOM / 4; k++) random_request();
    end
    calm = 0;
    req.valid <= 1'b0;

    repeat (LATENCY) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY * 2) @(posedge clk_i);
    $display("sent %0d requests, checked %0d responses, %0d full-table rejections",
             accepted, responses, rejects);
    $display("covered four penalty settings, a long output stall, random gaps");
    if (err_count == 0 && pending == 0) begin
      $display("PASS bus_slot_reservation_scheduler_top");
    end else begin
      $display("FAIL bus_slot_reservation_scheduler_top");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/bsrs_pkg.sv
rtl/bsrs_if.sv
rtl/bsrs_cell.sv
rtl/bus_slot_reservation_scheduler_top.sv
sim/bsrs_checker.sv
sim/bus_slot_reservation_scheduler_top_tb.sv
